[hw/rtl/ensp_pkg.sv]
package ensp_pkg;

    localparam int DATA_W    = 32;
    localparam int UPR_W     = 19;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = DATA_W + UPR_W;
    localparam int CNT_W     = $clog2(DATA_W + 1);

    localparam int REV_BITS_DEF = 18;
    localparam int TURNS_DEF    = 4096;

    localparam logic [UPR_W-1:0]  UPR_RST    = 19'd262144;
    localparam logic [DATA_W-1:0] TOTAL_RST  = 32'h4000_0000;
    localparam logic [DATA_W-1:0] PRESET_RST = 32'd100;
    localparam logic [DATA_W:0]   FULL_RANGE = 33'h1_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_EN = 2'd0,
        CFG_UPR      = 2'd1,
        CFG_TOTAL    = 2'd2,
        CFG_PRESET   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_UNSCALED = 2'd1,
        MODE_SCALED   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_M1_START,
        ST_M1_WAIT,
        ST_CORR,
        ST_M2_START,
        ST_M2_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic cap_in;
        logic mul;
        logic mod1_start;
        logic corr;
        logic mod2_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/ensp_mod.sv]
module ensp_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ensp_pkg::DATA_W-1:0]  i_dividend,
    input  logic [ensp_pkg::DATA_W:0]    i_divisor,
    output logic                         o_done,
    output logic [ensp_pkg::DATA_W-1:0]  o_rem
);

    logic                         r_busy;
    logic                         r_done;
    logic [ensp_pkg::CNT_W-1:0]   r_cnt;
    logic [ensp_pkg::DATA_W-1:0]  r_rem;
    logic [ensp_pkg::DATA_W-1:0]  r_dvd;
    logic [ensp_pkg::DATA_W:0]    r_div;
    logic [ensp_pkg::DATA_W:0]    n_shift;
    logic [ensp_pkg::DATA_W:0]    n_sub;
    logic [ensp_pkg::DATA_W-1:0]  n_rem;

    // one quotient bit per cycle, msb first
    always_comb begin
        n_shift = {r_rem, r_dvd[ensp_pkg::DATA_W-1]};
        n_sub   = n_shift - r_div;
        n_rem   = (n_shift >= r_div) ? n_sub[ensp_pkg::DATA_W-1:0]
                                     : n_shift[ensp_pkg::DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= ensp_pkg::CNT_W'(ensp_pkg::DATA_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == ensp_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[ensp_pkg::DATA_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[hw/rtl/ensp_dp.sv]
module ensp_dp #(
    parameter int REV_BITS = ensp_pkg::REV_BITS_DEF,
    parameter int TURNS    = ensp_pkg::TURNS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ensp_pkg::t_cmd                  i_cmd,
    output ensp_pkg::t_sts                  o_sts,
    input  logic [ensp_pkg::DATA_W-1:0]     i_raw_count,
    input  logic                            i_preset_request,
    input  logic                            i_cfg_we,
    input  logic [ensp_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [ensp_pkg::DATA_W-1:0]     i_cfg_wdata,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ensp_pkg::DATA_W-1:0]     o_position,
    output logic                            o_preset_taken
);

    localparam logic [63:0] NATIVE_FULL = (64'd1 << REV_BITS) * 64'(TURNS);
    localparam logic [ensp_pkg::DATA_W:0] NATIVE_RANGE =
        (NATIVE_FULL > 64'h1_0000_0000) ? ensp_pkg::FULL_RANGE
                                         : NATIVE_FULL[ensp_pkg::DATA_W:0];

    logic                            r_scale_en;
    logic [ensp_pkg::UPR_W-1:0]      r_upr;
    logic [ensp_pkg::DATA_W-1:0]     r_total;
    logic [ensp_pkg::DATA_W-1:0]     r_preset;
    logic [ensp_pkg::DATA_W-1:0]     r_offset;
    ensp_pkg::t_mode                 r_mode;
    logic [ensp_pkg::DATA_W-1:0]     r_raw;
    logic                            r_req;
    logic [ensp_pkg::PROD_W-1:0]     r_prod;
    logic [ensp_pkg::DATA_W-1:0]     r_v;
    logic                            r_out_valid;
    logic [ensp_pkg::DATA_W-1:0]     r_pos;
    logic                            r_taken;

    logic [ensp_pkg::PROD_W-1:0]     n_prod;
    logic [63:0]                     n_prod_sh;
    logic [ensp_pkg::DATA_W:0]       n_scaled_range;
    logic [ensp_pkg::DATA_W:0]       n_range;
    logic                            n_use_scale;
    logic [ensp_pkg::DATA_W-1:0]     n_offset;
    logic [ensp_pkg::DATA_W-1:0]     n_diff;
    logic [ensp_pkg::DATA_W-1:0]     n_v;
    logic                            n_mod_start;
    logic [ensp_pkg::DATA_W-1:0]     n_mod_dvd;
    logic [ensp_pkg::DATA_W:0]       n_mod_div;
    logic                            w_mod_done;
    logic [ensp_pkg::DATA_W-1:0]     w_mod_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_en <= 1'b0;
            r_upr      <= ensp_pkg::UPR_RST;
            r_total    <= ensp_pkg::TOTAL_RST;
            r_preset   <= ensp_pkg::PRESET_RST;
        end else if (i_cfg_we) begin
            unique case (ensp_pkg::t_cfg_idx'(i_cfg_addr))
                ensp_pkg::CFG_SCALE_EN: r_scale_en <= i_cfg_wdata[0];
                ensp_pkg::CFG_UPR:      r_upr      <= i_cfg_wdata[ensp_pkg::UPR_W-1:0];
                ensp_pkg::CFG_TOTAL:    r_total    <= i_cfg_wdata;
                ensp_pkg::CFG_PRESET:   r_preset   <= i_cfg_wdata;
            endcase
        end
    end

    always_comb begin
        n_prod         = {{ensp_pkg::DATA_W{1'b0}}, r_upr}
                       * {{ensp_pkg::UPR_W{1'b0}}, r_raw};
        n_prod_sh      = {{(64 - ensp_pkg::PROD_W){1'b0}}, r_prod} >> REV_BITS;
        n_scaled_range = (r_total == '0) ? ensp_pkg::FULL_RANGE : {1'b0, r_total};
        n_range        = r_scale_en ? n_scaled_range : NATIVE_RANGE;
        // scaling mode is taken from the state held before this item
        n_use_scale    = r_scale_en && (r_mode != ensp_pkg::MODE_UNSCALED);
        n_offset       = r_req ? (w_mod_rem - r_preset) : r_offset;
        n_diff         = w_mod_rem - n_offset;
        n_v            = n_diff[ensp_pkg::DATA_W-1] ? (n_diff + n_range[ensp_pkg::DATA_W-1:0])
                                                    : n_diff;
        n_mod_start    = i_cmd.mod1_start || i_cmd.mod2_start;
        if (i_cmd.mod2_start) begin
            n_mod_dvd = r_v;
            n_mod_div = n_range;
        end else if (n_use_scale) begin
            n_mod_dvd = n_prod_sh[ensp_pkg::DATA_W-1:0];
            n_mod_div = n_scaled_range;
        end else begin
            n_mod_dvd = r_raw;
            n_mod_div = NATIVE_RANGE;
        end
    end

    ensp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_mod_start),
        .i_dividend (n_mod_dvd),
        .i_divisor  (n_mod_div),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_mode   <= ensp_pkg::MODE_NONE;
        end else if (i_cmd.corr && r_req) begin
            r_offset <= n_offset;
            r_mode   <= r_scale_en ? ensp_pkg::MODE_SCALED : ensp_pkg::MODE_UNSCALED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_raw <= i_raw_count;
            r_req <= i_preset_request;
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.corr) begin
            r_v <= n_v;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pos   <= w_mod_rem;
            r_taken <= r_req;
        end
    end

    assign o_sts.mod_done = w_mod_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_position     = r_pos;
    assign o_preset_taken = r_taken;

endmodule

[hw/rtl/ensp_ctrl.sv]
module ensp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ensp_pkg::t_sts  i_sts,
    output ensp_pkg::t_cmd  o_cmd
);

    ensp_pkg::t_state r_state;
    ensp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ensp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ensp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ensp_pkg::ST_MUL;
                end
            end
            ensp_pkg::ST_MUL:      n_state = ensp_pkg::ST_M1_START;
            ensp_pkg::ST_M1_START: n_state = ensp_pkg::ST_M1_WAIT;
            ensp_pkg::ST_M1_WAIT: begin
                if (i_sts.mod_done) begin
                    n_state = ensp_pkg::ST_CORR;
                end
            end
            ensp_pkg::ST_CORR:     n_state = ensp_pkg::ST_M2_START;
            ensp_pkg::ST_M2_START: n_state = ensp_pkg::ST_M2_WAIT;
            ensp_pkg::ST_M2_WAIT: begin
                if (i_sts.mod_done) begin
                    n_state = ensp_pkg::ST_OUT;
                end
            end
            ensp_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = ensp_pkg::ST_IDLE;
                end
            end
            default: n_state = ensp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ensp_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.cap_in = i_in_valid;
            end
            ensp_pkg::ST_MUL:      o_cmd.mul        = 1'b1;
            ensp_pkg::ST_M1_START: o_cmd.mod1_start = 1'b1;
            ensp_pkg::ST_CORR:     o_cmd.corr       = 1'b1;
            ensp_pkg::ST_M2_START: o_cmd.mod2_start = 1'b1;
            ensp_pkg::ST_OUT:      o_cmd.out_load   = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[hw/rtl/encoder_scale_and_preset_top.sv]
// each input goes through the multiply state, a pass of the 32-step bit-serial
//   modulo unit, the correction state, a second modulo pass and the handoff state,
//   which waits until the output register is free; one item is in flight at a time
// the input is taken again while a finished result waits in the output register
// reset: synchronous active-low i_rst_n clears offset, preset mode, config registers
//   to their defaults and the controller to idle; no clearing pass
module encoder_scale_and_preset_top #(
    parameter int REV_BITS = ensp_pkg::REV_BITS_DEF,
    parameter int TURNS    = ensp_pkg::TURNS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ensp_pkg::DATA_W-1:0]     s_axis_tdata,   // raw_count
    input  logic                            s_axis_tuser,   // preset_request
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ensp_pkg::DATA_W-1:0]     m_axis_tdata,   // position
    output logic                            m_axis_tuser,   // preset_taken
    input  logic                            i_cfg_we,
    input  logic [ensp_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [ensp_pkg::DATA_W-1:0]     i_cfg_wdata
);

    ensp_pkg::t_cmd w_cmd;
    ensp_pkg::t_sts w_sts;

    ensp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ensp_dp #(
        .REV_BITS (REV_BITS),
        .TURNS    (TURNS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_raw_count      (s_axis_tdata),
        .i_preset_request (s_axis_tuser),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_position       (m_axis_tdata),
        .o_preset_taken   (m_axis_tuser)
    );

endmodule
